[rtl/core/ssmd_pkg.sv]
// shared types, constants and segment decode for the seven-segment mux driver
`timescale 1ns / 1ps

package ssmd_pkg;

    // input kinds carried on s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_DWELL_TICKS     = 2'd0;
    localparam logic [1:0] REG_REFRESH_LIMIT   = 2'd1;
    localparam logic [1:0] REG_POINT_DIGIT     = 2'd2;
    localparam logic [1:0] REG_INVERT_SEGMENTS = 2'd3;

    // reset values of the configuration registers
    localparam logic [7:0]  DWELL_RESET  = 8'd5;
    localparam logic [15:0] LIMIT_RESET  = 16'd1000;
    localparam logic [1:0]  POINT_RESET  = 2'd1;
    localparam logic        INVERT_RESET = 1'b1;

    // decimal point segment
    localparam logic [7:0] SEG_POINT = 8'h80;

    // divide by ten as multiply by reciprocal, exact for 14-bit values
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic [7:0]  dwell_ticks;
        logic [15:0] refresh_limit;
        logic [1:0]  point_digit;
        logic        invert_segments;
    } cfg_t;

    // one unit of work for the shifter: a segment byte or the switch-off result
    typedef struct packed {
        logic       done;
        logic [7:0] seg;
        logic [3:0] mask;
    } job_t;

    // segment byte for one digit, with point and polarity applied
    function automatic logic [7:0] seg_code(input logic [3:0] digit,
                                            input logic point,
                                            input logic invert);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        if (point)
        begin
            pat = pat | SEG_POINT;
        end
        if (invert)
        begin
            pat = ~pat;
        end
        return pat;
    endfunction

endpackage

[rtl/core/ssmd_front.sv]
// front end: takes load and tick transactions, splits digits, schedules refresh jobs
`timescale 1ns / 1ps

module ssmd_front #(
    parameter int NUM_DIGITS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ssmd_pkg::cfg_t  cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            s_tuser,
    input  logic [13:0]     s_value,
    input  logic            q_full,
    output logic            q_push,
    output ssmd_pkg::job_t  q_job
);
    import ssmd_pkg::*;

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_PUSH
    } state_t;

    state_t             state_reg, state_next;
    logic [13:0]        value_reg, value_next;
    logic [IDX_W-1:0]   split_idx_reg, split_idx_next;
    logic [IDX_W-1:0]   digit_idx_reg, digit_idx_next;
    logic [7:0]         dwell_reg, dwell_next;
    logic [15:0]        slot_reg, slot_next;
    logic               running_reg, running_next;
    logic [3:0]         digit_reg [NUM_DIGITS];
    logic               digit_we;

    logic               accept;
    logic [7:0]         dwell_eff;
    logic [15:0]        limit_eff;
    logic [7:0]         dwell_inc;
    logic [15:0]        slot_inc;
    logic [29:0]        prod;
    logic [10:0]        quot;
    logic [13:0]        tens;
    logic [3:0]         rem;
    logic [3:0]         cur_digit;
    logic               cur_point;
    logic [3:0]         cur_mask;

    // zero dwell and zero limit behave as one
    assign dwell_eff = (cfg.dwell_ticks == 8'd0) ? 8'd1 : cfg.dwell_ticks;
    assign limit_eff = (cfg.refresh_limit == 16'd0) ? 16'd1 : cfg.refresh_limit;
    assign dwell_inc = dwell_reg + 8'd1;
    assign slot_inc  = slot_reg + 16'd1;

    // one decimal digit per cycle: quotient and remainder by ten
    assign prod = 30'(value_reg) * 30'(DIV10_MUL);
    assign quot = prod[DIV10_SHIFT +: 11];
    assign tens = 14'({quot, 3'b000}) + 14'({quot, 1'b0});
    assign rem  = 4'(value_reg - tens);

    // segment job for the digit now in the slot
    assign cur_digit = digit_reg[digit_idx_reg];
    assign cur_point = (32'(digit_idx_reg) == 32'(cfg.point_digit));

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            cur_mask[b] = (32'(digit_idx_reg) == b);
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        split_idx_next = split_idx_reg;
        digit_idx_next = digit_idx_reg;
        dwell_next     = dwell_reg;
        slot_next      = slot_reg;
        running_next   = running_reg;
        digit_we       = 1'b0;
        q_push         = 1'b0;
        q_job          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_LOAD)
                    begin
                        value_next     = s_value;
                        split_idx_next = IDX_W'(NUM_DIGITS - 1);
                        digit_idx_next = '0;
                        dwell_next     = 8'd0;
                        slot_next      = 16'd0;
                        running_next   = 1'b1;
                        state_next     = ST_SPLIT;
                    end
                    else if (running_reg)
                    begin
                        if (dwell_inc < dwell_eff)
                        begin
                            dwell_next = dwell_inc;
                        end
                        else
                        begin
                            dwell_next = 8'd0;
                            slot_next  = slot_inc;
                            if (slot_inc >= limit_eff)
                            begin
                                running_next = 1'b0;
                                q_push       = 1'b1;
                                q_job.done   = 1'b1;
                            end
                            else
                            begin
                                if (32'(digit_idx_reg) == NUM_DIGITS - 1)
                                begin
                                    digit_idx_next = '0;
                                end
                                else
                                begin
                                    digit_idx_next = digit_idx_reg + IDX_W'(1);
                                end
                                state_next = ST_PUSH;
                            end
                        end
                    end
                end
            end
            ST_SPLIT:
            begin
                digit_we   = 1'b1;
                value_next = 14'(quot);
                if (split_idx_reg == '0)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    split_idx_next = split_idx_reg - IDX_W'(1);
                end
            end
            ST_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    q_job.done = 1'b0;
                    q_job.seg  = seg_code(cur_digit, cur_point, cfg.invert_segments);
                    q_job.mask = cur_mask;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and digit store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            value_reg     <= '0;
            split_idx_reg <= '0;
            digit_idx_reg <= '0;
            dwell_reg     <= '0;
            slot_reg      <= '0;
            running_reg   <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            value_reg     <= value_next;
            split_idx_reg <= split_idx_next;
            digit_idx_reg <= digit_idx_next;
            dwell_reg     <= dwell_next;
            slot_reg      <= slot_next;
            running_reg   <= running_next;
            if (digit_we)
            begin
                digit_reg[split_idx_reg] <= rem;
            end
        end
    end

    // a digit written during the split is always a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_we |-> (rem < 4'd10))
        else $error("digit split produced a remainder above nine");

    // a job leaves only from idle or push
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full && (state_reg != ST_SPLIT))
        else $error("job pushed while splitting or queue full");

endmodule

[rtl/core/ssmd_queue.sv]
// two-entry job queue between the front end and the shifter
`timescale 1ns / 1ps

module ssmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ssmd_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ssmd_pkg::job_t  pop_job
);
    import ssmd_pkg::*;

    job_t        mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job queue underflow");

endmodule

[rtl/core/ssmd_back.sv]
// back end: shifts segment bytes out one bit per transaction through an output register
`timescale 1ns / 1ps

module ssmd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  ssmd_pkg::job_t  q_job,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            m_tlast,
    output logic [15:0]     m_tdata
);
    import ssmd_pkg::*;

    logic        busy_reg;
    logic [7:0]  seg_reg;
    logic [3:0]  mask_reg;
    logic [2:0]  bit_cnt_reg;
    logic        valid_reg;
    logic        bit_reg;
    logic [2:0]  idx_reg;
    logic        last_reg;
    logic [3:0]  omask_reg;
    logic        done_reg;
    logic        advance;

    assign advance = !valid_reg || m_tready;
    assign q_pop   = advance && !busy_reg && !q_empty;

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'd0, done_reg, omask_reg, idx_reg, bit_reg};

    // shifter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            seg_reg     <= '0;
            mask_reg    <= '0;
            bit_cnt_reg <= '0;
            valid_reg   <= 1'b0;
            bit_reg     <= 1'b0;
            idx_reg     <= '0;
            last_reg    <= 1'b0;
            omask_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (busy_reg)
            begin
                valid_reg   <= 1'b1;
                bit_reg     <= seg_reg[3'd7 - bit_cnt_reg];
                idx_reg     <= bit_cnt_reg;
                last_reg    <= (bit_cnt_reg == 3'd7);
                omask_reg   <= mask_reg;
                done_reg    <= 1'b0;
                bit_cnt_reg <= bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (!q_empty)
            begin
                valid_reg <= 1'b1;
                if (q_job.done)
                begin
                    bit_reg   <= 1'b0;
                    idx_reg   <= 3'd0;
                    last_reg  <= 1'b0;
                    omask_reg <= 4'd0;
                    done_reg  <= 1'b1;
                end
                else
                begin
                    seg_reg     <= q_job.seg;
                    mask_reg    <= q_job.mask;
                    bit_reg     <= q_job.seg[7];
                    idx_reg     <= 3'd0;
                    last_reg    <= 1'b0;
                    omask_reg   <= q_job.mask;
                    done_reg    <= 1'b0;
                    bit_cnt_reg <= 3'd1;
                    busy_reg    <= 1'b1;
                end
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // latch pulse only on the last bit of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (idx_reg == 3'd7) && !done_reg)
        else $error("latch outside last bit");

    // switch-off result carries no enable and no latch
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && done_reg) |-> (omask_reg == 4'd0) && !last_reg && !busy_reg)
        else $error("malformed switch-off result");

endmodule

[rtl/core/seven_segment_mux_driver_top.sv]
// top level of the multiplexed seven-segment display driver
`timescale 1ns / 1ps

// Input stream: s_tuser selects load (0) or tick (1); s_tdata[13:0] holds the
// value in hundredths for a load. A load splits the value into NUM_DIGITS
// decimal digits, one digit per cycle, then queues digit 0's segment byte.
// A tick while lit advances the dwell count; at the end of a slot it queues the next
// digit's byte, or the switch-off result once the slot limit is reached.
// Output stream: one transaction per serial bit, MSB first, eight per byte,
// m_tlast on the eighth (latch pulse). A switch-off is one transaction.
// The shifter emits one bit per cycle while m_tready allows; a load holds the input
// (s_tready low) while the digit splitter runs and until its byte is queued.
// A two-entry job queue lets ticks and loads be taken while a byte shifts.
// When m_tready is low the output register holds and the queue fills, after
// which s_tready drops. Configuration writes on cfg_we are expected while idle.
// Reset clears the display to off, digits to zero and the registers to
// dwell 5, limit 1000, point on digit 1, inverted segments.
module seven_segment_mux_driver_top #(
    parameter int NUM_DIGITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [13:0] value_hundredths, [15:14] zero
    input  logic        s_tuser,     // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [0] data_bit, [3:1] bit_index,
                                     // [7:4] digit_enable_mask, [8] display_done
    output logic        m_tlast      // latch_now
);
    import ssmd_pkg::*;

    cfg_t  cfg_reg;
    logic  q_push;
    job_t  q_job_in;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    job_t  q_job_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dwell_ticks     <= DWELL_RESET;
            cfg_reg.refresh_limit   <= LIMIT_RESET;
            cfg_reg.point_digit     <= POINT_RESET;
            cfg_reg.invert_segments <= INVERT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DWELL_TICKS:     cfg_reg.dwell_ticks     <= cfg_wdata[7:0];
                REG_REFRESH_LIMIT:   cfg_reg.refresh_limit   <= cfg_wdata;
                REG_POINT_DIGIT:     cfg_reg.point_digit     <= cfg_wdata[1:0];
                REG_INVERT_SEGMENTS: cfg_reg.invert_segments <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    ssmd_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_value  (s_tdata[13:0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job_in)
    );

    ssmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (q_job_out)
    );

    ssmd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (q_job_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tdata  (m_tdata)
    );

endmodule

[bench/tb_seven_segment_mux_driver_top.sv]
// self-checking testbench for the seven-segment mux driver top level
`timescale 1ns / 1ps

module tb_seven_segment_mux_driver_top;

    import ssmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int REPORT_MAX     = 10;

    // segment patterns for digits 0 to 9, point off, true polarity
    localparam logic [7:0] GLYPH [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                           8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    // one serial bit as seen on the output stream
    typedef struct packed {
        logic       data_bit;
        logic [2:0] bit_index;
        logic       latch_now;
        logic [3:0] digit_mask;
        logic       display_done;
    } seg_bit_t;

    // one line of the directed script: a register setting or an input item
    typedef struct {
        bit          is_cfg;
        logic [7:0]  dwell;
        logic [15:0] limit;
        logic [1:0]  point;
        logic        invert;
        logic        cmd;
        logic [13:0] value;
        bit          typed;
        int          nres;
        logic [7:0]  seg;
        logic [3:0]  mask;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // display model state and register copies
    logic [7:0]  cfg_dwell;
    logic [15:0] cfg_limit;
    logic [1:0]  cfg_point;
    logic        cfg_invert;
    logic [3:0]  digit_val [0:3];
    logic [1:0]  cur_digit;
    int          dwell_cnt;
    int          slot_cnt;
    bit          lit;

    seg_bit_t    pending_bits [$];
    seg_bit_t    fresh_bits [$];
    stim_row_t   script [$];

    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    seven_segment_mux_driver_top #(
        .NUM_DIGITS(4)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // eight serial bits of one segment byte, msb first
    task automatic queue_byte(input logic [7:0] seg, input logic [3:0] mask);
        seg_bit_t b;
        for (int k = 0; k < 8; k++)
        begin
            b.data_bit     = seg[7 - k];
            b.bit_index    = 3'(k);
            b.latch_now    = (k == 7);
            b.digit_mask   = mask;
            b.display_done = 1'b0;
            fresh_bits.push_back(b);
        end
    endtask

    // single switch-off transaction
    task automatic queue_switch_off();
        seg_bit_t b;
        b = '0;
        b.display_done = 1'b1;
        fresh_bits.push_back(b);
    endtask

    // byte of the digit now selected, point and polarity applied
    task automatic queue_current_digit();
        logic [7:0] seg;
        seg = GLYPH[digit_val[cur_digit]];
        if (cur_digit == cfg_point)
        begin
            seg = seg | SEG_POINT;
        end
        if (cfg_invert)
        begin
            seg = ~seg;
        end
        queue_byte(seg, 4'b0001 << cur_digit);
    endtask

    // serial bits caused by one input item, left in fresh_bits
    task automatic display_step(input logic cmd, input logic [13:0] value);
        int v;
        int dwell_eff;
        int limit_eff;
        fresh_bits.delete();
        dwell_eff = (cfg_dwell == 8'd0) ? 1 : int'(cfg_dwell);
        limit_eff = (cfg_limit == 16'd0) ? 1 : int'(cfg_limit);
        if (cmd == CMD_LOAD)
        begin
            // decimal split, least significant digit last; higher places wrap
            v = int'(value);
            for (int i = 3; i >= 0; i--)
            begin
                digit_val[i] = 4'(v % 10);
                v = v / 10;
            end
            cur_digit = 2'd0;
            dwell_cnt = 0;
            slot_cnt  = 0;
            lit       = 1'b1;
            queue_current_digit();
        end
        else if (lit)
        begin
            dwell_cnt++;
            if (dwell_cnt >= dwell_eff)
            begin
                dwell_cnt = 0;
                slot_cnt++;
                if (slot_cnt >= limit_eff)
                begin
                    lit = 1'b0;
                    queue_switch_off();
                end
                else
                begin
                    cur_digit = cur_digit + 2'd1;
                    queue_current_digit();
                end
            end
        end
    endtask

    // offer one item on the input stream and return at its accepting edge
    task automatic send_item(input logic cmd, input logic [13:0] value);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, value};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // item accepted: predict it, or take the typed-in expectation instead
    task automatic log_item(input stim_row_t row);
        display_step(row.cmd, row.value);
        if (row.typed)
        begin
            fresh_bits.delete();
            if (row.nres == 8)
            begin
                queue_byte(row.seg, row.mask);
            end
            else if (row.nres == 1)
            begin
                queue_switch_off();
            end
        end
        foreach (fresh_bits[i])
        begin
            pending_bits.push_back(fresh_bits[i]);
        end
    endtask

    // wait until every expected transaction has come, plus settling time
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_bits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // all four registers, written while the block is idle
    task automatic program_regs(input logic [7:0] dwell, input logic [15:0] limit,
                                input logic [1:0] point, input logic invert);
        drain();
        write_reg(REG_DWELL_TICKS, {8'h00, dwell});
        write_reg(REG_REFRESH_LIMIT, limit);
        write_reg(REG_POINT_DIGIT, {14'h0000, point});
        write_reg(REG_INVERT_SEGMENTS, {15'h0000, invert});
        cfg_we     <= 1'b0;
        cfg_dwell  = dwell;
        cfg_limit  = limit;
        cfg_point  = point;
        cfg_invert = invert;
    endtask

    task automatic add_cfg(input logic [7:0] dwell, input logic [15:0] limit,
                           input logic [1:0] point, input logic invert);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.dwell  = dwell;
        r.limit  = limit;
        r.point  = point;
        r.invert = invert;
        script.push_back(r);
    endtask

    task automatic add_item(input logic cmd, input logic [13:0] value, input bit typed,
                            input int nres, input logic [7:0] seg, input logic [3:0] mask);
        stim_row_t r;
        r = '{default: '0};
        r.cmd   = cmd;
        r.value = value;
        r.typed = typed;
        r.nres  = nres;
        r.seg   = seg;
        r.mask  = mask;
        script.push_back(r);
    endtask

    // receiver: random back-pressure, or a long hold when asked
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // compare every output transaction with the oldest expectation
    always @(posedge clk)
    begin
        seg_bit_t got;
        seg_bit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.data_bit     = m_tdata[0];
            got.bit_index    = m_tdata[3:1];
            got.latch_now    = m_tlast;
            got.digit_mask   = m_tdata[7:4];
            got.display_done = m_tdata[8];
            if (pending_bits.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                begin
                    $display("unexpected transaction: bit %0d idx %0d latch %0d mask %h done %0d",
                             got.data_bit, got.bit_index, got.latch_now, got.digit_mask,
                             got.display_done);
                end
            end
            else
            begin
                want = pending_bits.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                    begin
                        $display("mismatch: want bit %0d idx %0d latch %0d mask %h done %0d",
                                 want.data_bit, want.bit_index, want.latch_now,
                                 want.digit_mask, want.display_done);
                        $display("          got  bit %0d idx %0d latch %0d mask %h done %0d",
                                 got.data_bit, got.bit_index, got.latch_now,
                                 got.digit_mask, got.display_done);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("seven_segment_mux_driver_top regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // main stimulus
    initial
    begin
        stim_row_t row;
        int n_items [0:3];
        int r;
        logic [13:0] value;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_LOAD;

        // power-up state of the display and its registers
        cfg_dwell  = DWELL_RESET;
        cfg_limit  = LIMIT_RESET;
        cfg_point  = POINT_RESET;
        cfg_invert = INVERT_RESET;
        foreach (digit_val[i])
        begin
            digit_val[i] = 4'd0;
        end
        cur_digit = 2'd0;
        dwell_cnt = 0;
        slot_cnt  = 0;
        lit       = 1'b0;

        // directed script, power-up registers first
        add_item(CMD_TICK, 14'h3FFF, 1, 0, 8'h00, 4'h0);    // tick while off
        add_item(CMD_LOAD, 14'd0, 1, 8, 8'hC0, 4'h1);
        add_item(CMD_LOAD, 14'd9999, 1, 8, 8'h90, 4'h1);
        add_item(CMD_LOAD, 14'h3FFF, 1, 8, 8'h82, 4'h1);    // above 9999, wraps
        add_item(CMD_LOAD, 14'h2AAA, 0, 0, 8'h00, 4'h0);
        add_item(CMD_LOAD, 14'h1555, 0, 0, 8'h00, 4'h0);
        add_item(CMD_LOAD, 14'd1234, 0, 0, 8'h00, 4'h0);
        repeat (10) add_item(CMD_TICK, 14'(10 * script.size()), 0, 0, 8'h00, 4'h0);
        // one tick per slot, switch-off after two slots, true polarity
        add_cfg(8'd1, 16'd2, 2'd3, 1'b0);
        add_item(CMD_LOAD, 14'd8888, 1, 8, 8'h7F, 4'h1);
        add_item(CMD_TICK, 14'h0000, 0, 0, 8'h00, 4'h0);
        add_item(CMD_TICK, 14'h0000, 1, 1, 8'h00, 4'h0);
        add_item(CMD_TICK, 14'h3FFF, 1, 0, 8'h00, 4'h0);
        // zero dwell and zero limit both act as one
        add_cfg(8'd0, 16'd0, 2'd3, 1'b0);
        add_item(CMD_LOAD, 14'd5, 1, 8, 8'h3F, 4'h1);
        add_item(CMD_TICK, 14'h0000, 1, 1, 8'h00, 4'h0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 24;
        sink_idle_pct = 61;
        foreach (script[i])
        begin
            row = script[i];
            if (row.is_cfg)
            begin
                program_regs(row.dwell, row.limit, row.point, row.invert);
            end
            else
            begin
                send_item(row.cmd, row.value);
                log_item(row);
            end
        end

        // random phases: settings and idling change between them
        n_items = '{50, 30, 40, 40};
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: program_regs(8'd2, 16'd7, 2'd0, 1'b1);
                1: program_regs(8'd255, 16'd65535, 2'd2, 1'b0);
                2: program_regs(8'd1, 16'd3, 2'd3, 1'b1);
                default: program_regs(8'($urandom_range(1, 4)), 16'($urandom_range(2, 20)),
                                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            endcase
            src_idle_pct  = (p == 0) ? 24 : (p == 1) ? 61 : 0;
            sink_idle_pct = (p == 0) ? 61 : (p == 1) ? 24 : 0;
            for (int n = 0; n < n_items[p]; n++)
            begin
                row = '{default: '0};
                r = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0: value = 14'($urandom_range(0, 9999));
                    1: value = (r < 25) ? 14'd0 : (r < 50) ? 14'd9999 :
                               (r < 75) ? 14'd10000 : 14'h3FFF;
                    default: value = 14'($urandom_range(0, 16383));
                endcase
                row.value = value;
                row.cmd   = ($urandom_range(0, 99) < 20) ? CMD_LOAD : CMD_TICK;
                // long receiver hold while a burst of loads fills the block
                if (p == 0 && n == 10)
                begin
                    hold_req = 1'b1;
                end
                if (p == 0 && n >= 10 && n < 16)
                begin
                    row.cmd = CMD_LOAD;
                end
                send_item(row.cmd, row.value);
                log_item(row);
            end
        end

        drain();
        if (fail_count == 0)
        begin
            $display("seven_segment_mux_driver_top regression: pass");
        end
        else
        begin
            $display("seven_segment_mux_driver_top regression: fail");
        end
        $finish;
    end

endmodule
